/* src/iee_pkg.sv */
package iee_pkg;

    // Default sizes.
    localparam int NestDepthDefault = 16;
    localparam int IndexBitsDefault = 16;
    localparam int QueueDepth       = 4;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CLOSE      = 3'd1;
    localparam logic [2:0] ST_NUMBER     = 3'd2;
    localparam logic [2:0] ST_DIVZERO    = 3'd3;
    localparam logic [2:0] ST_UNEXPECTED = 3'd4;
    localparam logic [2:0] ST_DEEP       = 3'd5;

    // Pending operator codes.
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_A    = 2'd1;
    localparam logic [1:0] OP_B    = 2'd2;

    // Character classes assigned by the front end.
    localparam logic [3:0] CL_NONE  = 4'd0;
    localparam logic [3:0] CL_DIGIT = 4'd1;
    localparam logic [3:0] CL_WS    = 4'd2;
    localparam logic [3:0] CL_MINUS = 4'd3;
    localparam logic [3:0] CL_PLUS  = 4'd4;
    localparam logic [3:0] CL_STAR  = 4'd5;
    localparam logic [3:0] CL_SLASH = 4'd6;
    localparam logic [3:0] CL_OPEN  = 4'd7;
    localparam logic [3:0] CL_CLOSE = 4'd8;
    localparam logic [3:0] CL_OTHER = 4'd9;

    typedef struct packed {
        logic [7:0] character;
        logic       has_character;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
        logic [15:0]        error_position;
    } t_out_item;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        logic [3:0]  cls;
        logic [3:0]  digit;
        logic        has;
        logic        last;
        logic [31:0] index;
    } t_token;

endpackage

/* src/iee_front.sv */
module iee_front #(
    parameter int INDEX_BITS = iee_pkg::IndexBitsDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  iee_pkg::t_in_item i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output iee_pkg::t_token   o_data
);
    localparam logic [INDEX_BITS-1:0] IndexMax = '1;

    logic [INDEX_BITS-1:0] r_index, n_index;
    logic                  r_valid;
    iee_pkg::t_token       r_tok, n_tok;
    logic                  w_take;
    logic [7:0]            w_c;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_tok;
    assign w_c     = i_data.character;

    // Classify the character and tag it with its saturating position.
    always_comb begin
        n_tok        = '0;
        n_tok.has    = i_data.has_character;
        n_tok.last   = i_data.last;
        n_tok.digit  = w_c[3:0];
        n_tok.index  = 32'(r_index);
        if (w_c >= 8'd48 && w_c <= 8'd57) begin
            n_tok.cls = iee_pkg::CL_DIGIT;
        end else if (w_c == 8'd32 || (w_c >= 8'd9 && w_c <= 8'd13)) begin
            n_tok.cls = iee_pkg::CL_WS;
        end else begin
            case (w_c)
                8'd45:   n_tok.cls = iee_pkg::CL_MINUS;
                8'd43:   n_tok.cls = iee_pkg::CL_PLUS;
                8'd42:   n_tok.cls = iee_pkg::CL_STAR;
                8'd47:   n_tok.cls = iee_pkg::CL_SLASH;
                8'd40:   n_tok.cls = iee_pkg::CL_OPEN;
                8'd41:   n_tok.cls = iee_pkg::CL_CLOSE;
                default: n_tok.cls = iee_pkg::CL_OTHER;
            endcase
        end
        if (!i_data.has_character) begin
            n_tok.cls = iee_pkg::CL_NONE;
        end
        // The position counter restarts after each expression.
        n_index = r_index;
        if (i_data.last) begin
            n_index = '0;
        end else if (i_data.has_character && r_index != IndexMax) begin
            n_index = r_index + 1'b1;
        end
    end

    // Output register of the front end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_index <= '0;
        end else begin
            if (w_take) begin
                r_valid <= 1'b1;
                r_index <= n_index;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (w_take) begin
            r_tok <= n_tok;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_tok))
        else $error("front item changed while stalled");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_data.last |=> r_index == '0)
        else $error("position not cleared after last");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index == IndexMax && !(w_take && i_data.last) |=> r_index == IndexMax)
        else $error("position counter wrapped");

endmodule

/* src/iee_queue.sv */
module iee_queue #(
    parameter int DEPTH = iee_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  iee_pkg::t_token i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output iee_pkg::t_token o_data
);
    localparam int AW = $clog2(DEPTH);

    iee_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;
    logic            w_push, w_pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Small FIFO between classification and evaluation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count lost a push");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !w_push |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("queue count lost a pop");

endmodule

/* src/iee_div.sv */
module iee_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy, r_done, r_neg;
    logic [5:0]  r_cnt;
    logic [31:0] r_q, r_d;
    logic [32:0] r_rem;
    logic [32:0] w_trial;

    assign w_trial = {r_rem[31:0], r_q[31]} - {1'b0, r_d};
    assign o_done  = r_done;
    assign o_quot  = r_neg ? 32'(0) - r_q : r_q;

    // Restoring divider on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= i_num[31] ? 32'(0) - i_num : i_num;
            r_d   <= i_den[31] ? 32'(0) - i_den : i_den;
            r_neg <= i_num[31] ^ i_den[31];
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial;
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_q[31]};
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_cnt == 6'd1 |=> r_done)
        else $error("divider did not finish");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0 || $past(i_start) == 1'b0)
        else $error("divider count stale");

endmodule

/* src/iee_back.sv */
module iee_back #(
    parameter int NEST_DEPTH = iee_pkg::NestDepthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  iee_pkg::t_token    i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output iee_pkg::t_out_item o_data
);
    localparam int SW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int LW = $clog2(NEST_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_CHAR  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_REDO  = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  r_state;
    logic        r_after, r_digit, r_minus;
    logic [31:0] r_accum, r_sum, r_prod, r_fact;
    logic [1:0]  r_addop, r_mulop;
    logic [LW-1:0] r_level;
    logic [2:0]  r_err;
    logic [15:0] r_eidx;
    logic        r_ovalid;
    iee_pkg::t_out_item r_out;
    iee_pkg::t_token    r_tok;
    logic        r_fin;     // completion belongs to the end-of-item step
    logic        r_fin_busy;
    logic [33:0] r_sstk [NEST_DEPTH];
    logic [34:0] r_pstk [NEST_DEPTH];
    logic [33:0] r_srd;
    logic [34:0] r_prd;
    logic [31:0] r_mulres;

    logic        w_div_start, w_div_done;
    logic        w_push, w_close_ok;
    logic [31:0] w_quot, w_total, w_f;

    assign o_ready = r_state == S_CHAR && !r_ovalid && i_valid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign w_total = (r_addop == iee_pkg::OP_A) ? r_sum + r_prod :
                     (r_addop == iee_pkg::OP_B) ? r_sum - r_prod : r_prod;
    assign w_f     = r_minus ? 32'(0) - r_fact : r_fact;
    assign w_div_start = r_state == S_DIV && r_mulop == iee_pkg::OP_B && w_f != '0 &&
                         !r_fin_busy;

    // An open parenthesis that is taken saves the enclosing level.
    assign w_push = r_state == S_REDO && r_err == iee_pkg::ST_OK && !r_after &&
                    r_tok.cls == iee_pkg::CL_OPEN && r_level < LW'(NEST_DEPTH);
    // A close parenthesis that is taken restores the enclosing level.
    assign w_close_ok = r_err == iee_pkg::ST_OK && r_after &&
                        r_tok.cls == iee_pkg::CL_CLOSE && r_level != '0;

    iee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod),
        .i_den   (w_f),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Stack memories: written on open; the top entry is read whenever the level is nonzero and used on close.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_sstk[r_level[SW-1:0]] <= {r_addop, r_sum};
            r_pstk[r_level[SW-1:0]] <= {r_minus, r_mulop, r_prod};
        end
        if (r_level != '0) begin
            r_srd <= r_sstk[SW'(r_level - 1'b1)];
            r_prd <= r_pstk[SW'(r_level - 1'b1)];
        end
    end

    // Main sequencer: one character per pass, with extra steps for factors.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CHAR;
            r_after    <= 1'b0;
            r_digit    <= 1'b0;
            r_minus    <= 1'b0;
            r_accum    <= '0;
            r_sum      <= '0;
            r_prod     <= '0;
            r_addop    <= iee_pkg::OP_NONE;
            r_mulop    <= iee_pkg::OP_NONE;
            r_level    <= '0;
            r_err      <= iee_pkg::ST_OK;
            r_eidx     <= '0;
            r_ovalid   <= 1'b0;
            r_fin      <= 1'b0;
            r_fin_busy <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CHAR: begin
                    if (o_ready) begin
                        r_tok <= i_data;
                        if (!i_data.has || r_err != iee_pkg::ST_OK) begin
                            r_state <= i_data.last ? S_FINAL : S_CHAR;
                            r_fin   <= 1'b0;
                        end else if (!r_after && r_digit) begin
                            if (i_data.cls == iee_pkg::CL_DIGIT) begin
                                r_accum <= (r_accum << 3) + (r_accum << 1) +
                                           32'(i_data.digit);
                                r_state <= i_data.last ? S_FINAL : S_CHAR;
                            end else begin
                                // Complete the number, then redo this character.
                                r_digit <= 1'b0;
                                r_fact  <= r_accum;
                                r_fin   <= 1'b0;
                                r_state <= S_MUL;
                            end
                        end else begin
                            r_state <= S_REDO;
                        end
                    end
                end
                S_REDO: begin
                    if (w_close_ok) begin
                        r_state <= S_POP;
                    end else begin
                        r_state <= r_tok.last ? S_FINAL : S_CHAR;
                    end
                    if (r_err == iee_pkg::ST_OK && r_tok.cls != iee_pkg::CL_WS) begin
                        if (!r_after) begin
                            case (r_tok.cls)
                                iee_pkg::CL_DIGIT: begin
                                    r_digit <= 1'b1;
                                    r_accum <= 32'(r_tok.digit);
                                end
                                iee_pkg::CL_MINUS: begin
                                    if (!r_minus) r_minus <= 1'b1;
                                    else r_err <= iee_pkg::ST_NUMBER;
                                end
                                iee_pkg::CL_OPEN: begin
                                    if (r_level >= LW'(NEST_DEPTH)) begin
                                        r_err <= iee_pkg::ST_DEEP;
                                    end else begin
                                        r_level <= r_level + 1'b1;
                                        r_sum   <= '0;
                                        r_addop <= iee_pkg::OP_NONE;
                                        r_prod  <= '0;
                                        r_mulop <= iee_pkg::OP_NONE;
                                        r_minus <= 1'b0;
                                    end
                                end
                                default: r_err <= iee_pkg::ST_NUMBER;
                            endcase
                        end else begin
                            case (r_tok.cls)
                                iee_pkg::CL_STAR, iee_pkg::CL_SLASH: begin
                                    r_mulop <= (r_tok.cls == iee_pkg::CL_STAR) ?
                                               iee_pkg::OP_A : iee_pkg::OP_B;
                                    r_after <= 1'b0;
                                end
                                iee_pkg::CL_PLUS, iee_pkg::CL_MINUS: begin
                                    r_sum   <= w_total;
                                    r_addop <= (r_tok.cls == iee_pkg::CL_PLUS) ?
                                               iee_pkg::OP_A : iee_pkg::OP_B;
                                    r_mulop <= iee_pkg::OP_NONE;
                                    r_after <= 1'b0;
                                end
                                iee_pkg::CL_CLOSE: begin
                                    if (r_level != '0) begin
                                        r_fact  <= w_total;
                                        r_level <= r_level - 1'b1;
                                        r_fin   <= 1'b1;
                                    end else begin
                                        r_err  <= iee_pkg::ST_UNEXPECTED;
                                        r_eidx <= r_tok.index[15:0];
                                    end
                                end
                                default: begin
                                    if (r_level != '0) r_err <= iee_pkg::ST_CLOSE;
                                    else begin
                                        r_err  <= iee_pkg::ST_UNEXPECTED;
                                        r_eidx <= r_tok.index[15:0];
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_POP: begin
                    // Restore the enclosing level, then apply the factor.
                    r_sum   <= r_srd[31:0];
                    r_addop <= r_srd[33:32];
                    r_prod  <= r_prd[31:0];
                    r_mulop <= r_prd[33:32];
                    r_minus <= r_prd[34];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_mulres <= r_prod * w_f;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (r_fin_busy) begin
                        if (w_div_done) begin
                            r_fin_busy <= 1'b0;
                            r_prod     <= w_quot;
                            r_minus    <= 1'b0;
                            r_after    <= 1'b1;
                            r_state    <= r_fin ? (r_tok.last ? S_FINAL : S_CHAR) : S_REDO;
                        end
                    end else if (r_mulop == iee_pkg::OP_B) begin
                        if (w_f == '0) begin
                            r_err   <= iee_pkg::ST_DIVZERO;
                            r_minus <= 1'b0;
                            r_state <= r_fin ? (r_tok.last ? S_FINAL : S_CHAR) : S_REDO;
                        end else begin
                            r_fin_busy <= 1'b1;
                        end
                    end else begin
                        r_prod  <= (r_mulop == iee_pkg::OP_A) ? r_mulres : w_f;
                        r_minus <= 1'b0;
                        r_after <= 1'b1;
                        r_state <= r_fin ? (r_tok.last ? S_FINAL : S_CHAR) : S_REDO;
                    end
                end
                S_FINAL: begin
                    if (r_err == iee_pkg::ST_OK && r_digit) begin
                        // Trailing number closes before the result.
                        r_digit <= 1'b0;
                        r_fact  <= r_accum;
                        r_fin   <= 1'b1;
                        r_tok.last <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        if (r_err != iee_pkg::ST_OK) begin
                            r_out.status         <= r_err;
                            r_out.error_position <= r_eidx;
                            r_out.value          <= '0;
                        end else if (!r_after) begin
                            r_out.status         <= iee_pkg::ST_NUMBER;
                            r_out.error_position <= '0;
                            r_out.value          <= '0;
                        end else if (r_level != '0) begin
                            r_out.status         <= iee_pkg::ST_CLOSE;
                            r_out.error_position <= '0;
                            r_out.value          <= '0;
                        end else begin
                            r_out.status         <= iee_pkg::ST_OK;
                            r_out.error_position <= '0;
                            r_out.value          <= w_total;
                        end
                        r_ovalid <= 1'b1;
                        r_state  <= S_CHAR;
                        r_after  <= 1'b0;
                        r_digit  <= 1'b0;
                        r_minus  <= 1'b0;
                        r_accum  <= '0;
                        r_sum    <= '0;
                        r_prod   <= '0;
                        r_addop  <= iee_pkg::OP_NONE;
                        r_mulop  <= iee_pkg::OP_NONE;
                        r_level  <= '0;
                        r_err    <= iee_pkg::ST_OK;
                        r_eidx   <= '0;
                    end
                end
                default: r_state <= S_CHAR;
            endcase
        end
    end

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.status != iee_pkg::ST_OK |-> r_out.value == '0)
        else $error("nonzero value with error status");
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.status != iee_pkg::ST_UNEXPECTED |-> r_out.error_position == '0)
        else $error("position without unexpected character");
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(NEST_DEPTH))
        else $error("nesting level beyond stack");

endmodule

/* src/integer_expression_evaluator_core.sv */
// Streaming integer expression evaluator. Feed expression text one character per item;
// an item with last set yields one result (value, status, error position). The front
// end classifies a character into its output register and queues it. The back end takes
// a digit that extends a number directly and sends any other character through a redo
// step; completing a factor adds multiply and divide steps (and a pop step after a close
// parenthesis), a divide waits on the serial divider, and an expression end passes final
// and output steps before the result. The back end takes no item while a result waits.
module integer_expression_evaluator_core #(
    parameter int NEST_DEPTH = iee_pkg::NestDepthDefault,
    parameter int INDEX_BITS = iee_pkg::IndexBitsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  iee_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output iee_pkg::t_out_item o_data
);
    logic            w_fv, w_fr, w_qv, w_qr;
    iee_pkg::t_token w_ft, w_qt;

    iee_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (i_valid), .o_ready (o_ready), .i_data (i_data),
        .o_valid (w_fv), .i_ready (w_fr), .o_data (w_ft)
    );

    iee_queue #(.DEPTH(iee_pkg::QueueDepth)) u_queue (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (w_fv), .o_ready (w_fr), .i_data (w_ft),
        .o_valid (w_qv), .i_ready (w_qr), .o_data (w_qt)
    );

    iee_back #(.NEST_DEPTH(NEST_DEPTH)) u_back (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (w_qv), .o_ready (w_qr), .i_data (w_qt),
        .o_valid (o_valid), .i_ready (i_ready), .o_data (o_data)
    );

endmodule
